// ===== src/lfmc_pkg.sv =====
package lfmc_pkg;

    // Operating mode, one-hot
    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_STOP   = 6'b000010,
        MODE_FOLLOW = 6'b000100,
        MODE_LOST   = 6'b001000,
        MODE_ROTATE = 6'b010000,
        MODE_REACQ  = 6'b100000
    } mode_t;

    // Mode codes as seen on the result channel
    localparam logic [2:0] MODE_CODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_CODE_STOP   = 3'd1;
    localparam logic [2:0] MODE_CODE_FOLLOW = 3'd2;
    localparam logic [2:0] MODE_CODE_LOST   = 3'd3;
    localparam logic [2:0] MODE_CODE_ROTATE = 3'd4;
    localparam logic [2:0] MODE_CODE_REACQ  = 3'd5;

    // Motor actions
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_STOP  = 3'd1;
    localparam logic [2:0] ACT_PID   = 3'd2;
    localparam logic [2:0] ACT_FWD   = 3'd3;
    localparam logic [2:0] ACT_LEFT  = 3'd4;
    localparam logic [2:0] ACT_RIGHT = 3'd5;

    // Navigation commands
    localparam logic [2:0] NAV_STOP  = 3'd0;
    localparam logic [2:0] NAV_FWD   = 3'd1;
    localparam logic [2:0] NAV_LEFT  = 3'd2;
    localparam logic [2:0] NAV_RIGHT = 3'd3;
    localparam logic [2:0] NAV_ROT   = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_LOST_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_REACQ_THRESH = 3'd1;
    localparam logic [2:0] REG_BASE_SPEED   = 3'd2;
    localparam logic [2:0] REG_REACQ_SPEED  = 3'd3;
    localparam logic [2:0] REG_ROTATE_SPEED = 3'd4;

    localparam int unsigned CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [15:0] LOST_TIMEOUT_RST = 16'd1000;
    localparam logic [14:0] REACQ_THRESH_RST = 15'd2048;
    localparam logic [6:0]  BASE_SPEED_RST   = 7'd50;
    localparam logic [6:0]  REACQ_SPEED_RST  = 7'd30;
    localparam logic [6:0]  ROTATE_SPEED_RST = 7'd40;

    typedef struct packed {
        logic        cmd_valid;
        logic [2:0]  nav_cmd;
        logic        obstacle;
        logic        line_seen;
        logic signed [15:0] line_pos;
        logic [31:0] now_ms;
    } tick_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] motor_action;
        logic [6:0] motor_speed;
        logic       pid_clear;
    } result_t;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  last_cmd;
        logic [31:0] entry_time;
    } state_t;

    typedef struct packed {
        logic [15:0] lost_timeout_ms;
        logic [14:0] reacquire_threshold;
        logic [6:0]  base_speed;
        logic [6:0]  reacquire_speed;
        logic [6:0]  rotate_speed;
    } cfg_t;

    function automatic logic is_drive_cmd(input logic [2:0] c);
        return (c == NAV_FWD) || (c == NAV_LEFT) || (c == NAV_RIGHT);
    endfunction

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] code;
        case (m)
            MODE_IDLE:   code = MODE_CODE_IDLE;
            MODE_STOP:   code = MODE_CODE_STOP;
            MODE_FOLLOW: code = MODE_CODE_FOLLOW;
            MODE_LOST:   code = MODE_CODE_LOST;
            MODE_ROTATE: code = MODE_CODE_ROTATE;
            MODE_REACQ:  code = MODE_CODE_REACQ;
            default:     code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== src/lfmc_if.sv =====
// Tick channel: one control tick per transfer
interface lfmc_tick_if;
    logic        valid;
    logic        ready;
    logic        cmd_valid;
    logic [2:0]  nav_cmd;
    logic        obstacle;
    logic        line_seen;
    logic signed [15:0] line_pos;
    logic [31:0] now_ms;

    modport source (
        output valid, cmd_valid, nav_cmd, obstacle, line_seen, line_pos, now_ms,
        input  ready
    );
    modport sink (
        input  valid, cmd_valid, nav_cmd, obstacle, line_seen, line_pos, now_ms,
        output ready
    );
endinterface

// Result channel: one mode/motor result per transfer
interface lfmc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [2:0] motor_action;
    logic [6:0] motor_speed;
    logic       pid_clear;

    modport source (
        output valid, mode, motor_action, motor_speed, pid_clear,
        input  ready
    );
    modport sink (
        input  valid, mode, motor_action, motor_speed, pid_clear,
        output ready
    );
endinterface

// ===== src/line_follower_mode_controller.sv =====
// Channel   Role    Payload
// tick      sink    cmd_valid, nav_cmd, obstacle, line_seen, line_pos, now_ms
// result    source  mode, motor_action, motor_speed, pid_clear
// cfg_*     write   cfg_we, cfg_index, cfg_data (no read-back)
//
// One tick per clock sustained while the result is taken; each tick passes through
// the input register, then mode logic into the result register.
// The mode update is a single pass of compares and muxes between the two registers.
// rst_n (async, active low) sets mode idle, last command stop, entry time zero and
// the configuration registers to their defaults.
// A stalled result holds the result register; the input register still takes one
// more tick, after which tick.ready drops until the result is taken.
module line_follower_mode_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [2:0]                       cfg_index,
    input  logic [lfmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    lfmc_tick_if.sink                        tick,
    lfmc_result_if.source                    result
);
    import lfmc_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    tick_t   in_data_reg;
    state_t  state_reg;
    state_t  state_next;
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t res_next;
    logic    advance;
    logic    tick_xfer;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lost_timeout_ms     <= LOST_TIMEOUT_RST;
            cfg_reg.reacquire_threshold <= REACQ_THRESH_RST;
            cfg_reg.base_speed          <= BASE_SPEED_RST;
            cfg_reg.reacquire_speed     <= REACQ_SPEED_RST;
            cfg_reg.rotate_speed        <= ROTATE_SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOST_TIMEOUT: cfg_reg.lost_timeout_ms     <= cfg_data;
                REG_REACQ_THRESH: cfg_reg.reacquire_threshold <= cfg_data[14:0];
                REG_BASE_SPEED:   cfg_reg.base_speed          <= cfg_data[6:0];
                REG_REACQ_SPEED:  cfg_reg.reacquire_speed     <= cfg_data[6:0];
                REG_ROTATE_SPEED: cfg_reg.rotate_speed        <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // Handshake control
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;
    assign tick_xfer  = tick.valid && tick.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (tick_xfer)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            in_data_reg.cmd_valid <= tick.cmd_valid;
            in_data_reg.nav_cmd   <= tick.nav_cmd;
            in_data_reg.obstacle  <= tick.obstacle;
            in_data_reg.line_seen <= tick.line_seen;
            in_data_reg.line_pos  <= tick.line_pos;
            in_data_reg.now_ms    <= tick.now_ms;
        end
    end

    // Mode logic
    lfmc_step u_step (
        .state      (state_reg),
        .tick       (in_data_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // Controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= MODE_IDLE;
            state_reg.last_cmd   <= NAV_STOP;
            state_reg.entry_time <= 32'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= res_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.mode         = out_data_reg.mode;
    assign result.motor_action = out_data_reg.motor_action;
    assign result.motor_speed  = out_data_reg.motor_speed;
    assign result.pid_clear    = out_data_reg.pid_clear;

    // Checks
    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed tick produced no result");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("controller state changed without a tick");

    a_stop_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.motor_action == ACT_NONE ||
                           out_data_reg.motor_action == ACT_STOP))
        |-> out_data_reg.motor_speed == 7'd0)
        else $error("nonzero speed for none or stop");

    a_pid_in_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.motor_action == ACT_PID)
        |-> out_data_reg.mode == MODE_CODE_FOLLOW)
        else $error("PID drive outside follow mode");

    a_fwd_in_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.motor_action == ACT_FWD)
        |-> out_data_reg.mode == MODE_CODE_LOST)
        else $error("forward creep outside lost mode");

endmodule

// ===== src/lfmc_step.sv =====
// Next-state and result logic for one control tick
module lfmc_step (
    input  lfmc_pkg::state_t  state,
    input  lfmc_pkg::tick_t   tick,
    input  lfmc_pkg::cfg_t    cfg,
    output lfmc_pkg::state_t  state_next,
    output lfmc_pkg::result_t res
);
    import lfmc_pkg::*;

    logic [14:0] mag;
    logic [31:0] elapsed;
    logic        timed_out;
    logic        centered;
    mode_t       m;
    logic [2:0]  lc;
    logic [31:0] et;
    logic [2:0]  act;
    logic [6:0]  spd;
    logic        pid;
    logic [2:0]  turn_act;

    // Saturated magnitude of the line position
    always_comb
    begin
        if (!tick.line_pos[15])
            mag = tick.line_pos[14:0];
        else if (tick.line_pos == 16'sh8000)
            mag = 15'h7fff;
        else
            mag = 15'(~tick.line_pos + 16'sd1);
    end

    assign centered = (mag <= cfg.reacquire_threshold);

    always_comb
    begin
        m   = state.mode;
        lc  = state.last_cmd;
        et  = state.entry_time;
        act = ACT_NONE;
        spd = 7'd0;
        pid = 1'b0;

        // New navigation command
        if (tick.cmd_valid)
        begin
            lc = tick.nav_cmd;
            if (is_drive_cmd(tick.nav_cmd))
            begin
                m   = MODE_FOLLOW;
                et  = tick.now_ms;
                pid = 1'b1;
            end
            else if (tick.nav_cmd == NAV_ROT)
            begin
                m  = MODE_ROTATE;
                et = tick.now_ms;
            end
            else if (tick.nav_cmd == NAV_STOP)
            begin
                m   = MODE_STOP;
                et  = tick.now_ms;
                act = ACT_STOP;
            end
        end

        // Obstacle forces stop; a clear path resumes a stored drive or rotate command
        if (tick.obstacle)
        begin
            if (m != MODE_STOP)
            begin
                m   = MODE_STOP;
                et  = tick.now_ms;
                act = ACT_STOP;
                spd = 7'd0;
            end
        end
        else if (m == MODE_STOP)
        begin
            if (is_drive_cmd(lc))
            begin
                m   = MODE_FOLLOW;
                et  = tick.now_ms;
                pid = 1'b1;
            end
            else if (lc == NAV_ROT)
            begin
                m  = MODE_ROTATE;
                et = tick.now_ms;
            end
        end

        // Elapsed time uses the entry time as it stands at this point
        elapsed   = tick.now_ms - et;
        timed_out = (elapsed > {16'd0, cfg.lost_timeout_ms});
        turn_act  = (lc == NAV_LEFT) ? ACT_LEFT : ACT_RIGHT;

        // Run the current mode once
        case (m)
            MODE_FOLLOW:
            begin
                if (!tick.line_seen)
                begin
                    m  = MODE_LOST;
                    et = tick.now_ms;
                end
                else
                begin
                    act = ACT_PID;
                    spd = cfg.base_speed;
                end
            end
            MODE_LOST:
            begin
                if (tick.line_seen)
                begin
                    m   = MODE_FOLLOW;
                    et  = tick.now_ms;
                    pid = 1'b1;
                end
                else if (timed_out)
                begin
                    m  = MODE_ROTATE;
                    et = tick.now_ms;
                end
                else
                begin
                    act = ACT_FWD;
                    spd = cfg.reacquire_speed;
                end
            end
            MODE_ROTATE:
            begin
                if (tick.line_seen)
                begin
                    m  = MODE_REACQ;
                    et = tick.now_ms;
                end
                else
                begin
                    act = turn_act;
                    spd = cfg.rotate_speed;
                end
            end
            MODE_REACQ:
            begin
                if (!tick.line_seen)
                begin
                    m  = MODE_ROTATE;
                    et = tick.now_ms;
                end
                else if (centered)
                begin
                    m   = MODE_FOLLOW;
                    et  = tick.now_ms;
                    pid = 1'b1;
                end
                else
                begin
                    act = turn_act;
                    spd = cfg.reacquire_speed;
                end
            end
            default:
            begin
            end
        endcase

        state_next.mode       = m;
        state_next.last_cmd   = lc;
        state_next.entry_time = et;
        res.mode              = mode_code(m);
        res.motor_action      = act;
        res.motor_speed       = spd;
        res.pid_clear         = pid;
    end

endmodule

// ===== sim/line_follower_mode_controller_tb.sv =====
`timescale 1ns / 100ps

module line_follower_mode_controller_tb;
    import lfmc_pkg::*;

    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_TICKS = 1400;
    localparam int unsigned CFG_PHASES   = 6;
    localparam int unsigned RAND_PHASE   = 3;
    localparam int unsigned N_PROBES     = 26;
    localparam int unsigned PACE_SPAN    = 50;

    // Indexes past the register file; writes there must be dropped
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        tick_t   t;
        logic    known;
        result_t res;
    } probe_t;

    typedef struct packed {
        logic    known;
        result_t res;
    } tick_note_t;

    localparam result_t NO_RES = '0;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [2:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lfmc_tick_if   tick_ch ();
    lfmc_result_if res_ch ();

    line_follower_mode_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .result    (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mode tracker state and its copy of the registers
    cfg_t        nav_cfg;
    logic [2:0]  nav_mode;
    logic [2:0]  nav_last_cmd;
    logic [31:0] nav_entry_ms;

    // Per-tick scratch: last motor order, PID clear flag, tick time
    logic [2:0]  out_action;
    logic [6:0]  out_speed;
    logic        out_pid;
    logic [31:0] out_now;

    result_t     expected_results [$];
    tick_note_t  tick_notes [$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned failures      = 0;
    int unsigned ticks_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned idle_cycles   = 0;

    probe_t      probe_rows [N_PROBES];
    logic [15:0] reg_plan [CFG_PHASES][5];

    function automatic logic is_steering(input logic [2:0] c);
        return (c >= NAV_FWD) && (c <= NAV_RIGHT);
    endfunction

    function automatic void enter_mode(input logic [2:0] m);
        nav_mode     = m;
        nav_entry_ms = out_now;
        if (m == MODE_CODE_STOP || m == MODE_CODE_IDLE)
        begin
            out_action = ACT_STOP;
            out_speed  = '0;
        end
        if (m == MODE_CODE_FOLLOW)
            out_pid = 1'b1;
    endfunction

    // Search turns go left only after a left command
    function automatic void issue_turn(input logic [6:0] spd);
        out_action = (nav_last_cmd == NAV_LEFT) ? ACT_LEFT : ACT_RIGHT;
        out_speed  = spd;
    endfunction

    function automatic result_t predict_tick(input tick_t t);
        logic signed [15:0] pos;
        logic [15:0]        mag;
        result_t            r;
        out_now    = t.now_ms;
        out_action = ACT_NONE;
        out_speed  = '0;
        out_pid    = 1'b0;
        pos        = t.line_pos;

        // |pos| with the most negative value pinned to full scale
        if (pos == 16'sh8000)
            mag = 16'd32767;
        else if (pos[15])
            mag = 16'(-pos);
        else
            mag = 16'(pos);

        if (t.cmd_valid)
        begin
            nav_last_cmd = t.nav_cmd;
            if (is_steering(t.nav_cmd))
                enter_mode(MODE_CODE_FOLLOW);
            else if (t.nav_cmd == NAV_ROT)
                enter_mode(MODE_CODE_ROTATE);
            else if (t.nav_cmd == NAV_STOP)
                enter_mode(MODE_CODE_STOP);
        end

        // Obstacle overrides; a clear path resumes a stored drive or rotate command
        if (t.obstacle)
        begin
            if (nav_mode != MODE_CODE_STOP)
                enter_mode(MODE_CODE_STOP);
        end
        else if (nav_mode == MODE_CODE_STOP)
        begin
            if (is_steering(nav_last_cmd))
                enter_mode(MODE_CODE_FOLLOW);
            else if (nav_last_cmd == NAV_ROT)
                enter_mode(MODE_CODE_ROTATE);
        end

        case (nav_mode)
            MODE_CODE_FOLLOW:
                if (!t.line_seen)
                    enter_mode(MODE_CODE_LOST);
                else
                begin
                    out_action = ACT_PID;
                    out_speed  = nav_cfg.base_speed;
                end
            MODE_CODE_LOST:
                if (t.line_seen)
                    enter_mode(MODE_CODE_FOLLOW);
                else if ((out_now - nav_entry_ms) > {16'd0, nav_cfg.lost_timeout_ms})
                    enter_mode(MODE_CODE_ROTATE);
                else
                begin
                    out_action = ACT_FWD;
                    out_speed  = nav_cfg.reacquire_speed;
                end
            MODE_CODE_ROTATE:
                if (t.line_seen)
                    enter_mode(MODE_CODE_REACQ);
                else
                    issue_turn(nav_cfg.rotate_speed);
            MODE_CODE_REACQ:
                if (!t.line_seen)
                    enter_mode(MODE_CODE_ROTATE);
                else if (mag <= {1'b0, nav_cfg.reacquire_threshold})
                    enter_mode(MODE_CODE_FOLLOW);
                else
                    issue_turn(nav_cfg.reacquire_speed);
            default: ;
        endcase

        r.mode         = nav_mode;
        r.motor_action = out_action;
        r.motor_speed  = out_speed;
        r.pid_clear    = out_pid;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Register writes and tick transfers feed the tracker
    always @(posedge clk)
    begin : track_ticks
        tick_t      seen;
        tick_note_t note;
        result_t    want;
        if (!rst_n)
        begin
            nav_cfg.lost_timeout_ms     = LOST_TIMEOUT_RST;
            nav_cfg.reacquire_threshold = REACQ_THRESH_RST;
            nav_cfg.base_speed          = BASE_SPEED_RST;
            nav_cfg.reacquire_speed     = REACQ_SPEED_RST;
            nav_cfg.rotate_speed        = ROTATE_SPEED_RST;
            nav_mode                    = MODE_CODE_IDLE;
            nav_last_cmd                = NAV_STOP;
            nav_entry_ms                = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOST_TIMEOUT: nav_cfg.lost_timeout_ms     = cfg_data;
                    REG_REACQ_THRESH: nav_cfg.reacquire_threshold = cfg_data[14:0];
                    REG_BASE_SPEED:   nav_cfg.base_speed          = cfg_data[6:0];
                    REG_REACQ_SPEED:  nav_cfg.reacquire_speed     = cfg_data[6:0];
                    REG_ROTATE_SPEED: nav_cfg.rotate_speed        = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (tick_ch.valid && tick_ch.ready)
            begin
                seen.cmd_valid = tick_ch.cmd_valid;
                seen.nav_cmd   = tick_ch.nav_cmd;
                seen.obstacle  = tick_ch.obstacle;
                seen.line_seen = tick_ch.line_seen;
                seen.line_pos  = tick_ch.line_pos;
                seen.now_ms    = tick_ch.now_ms;
                want = predict_tick(seen);
                note = tick_notes.pop_front();
                if (note.known)
                    want = note.res;
                expected_results.push_back(want);
                ticks_taken++;
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: mode %0d action %0d speed %0d pid %0d",
                       res_ch.mode, res_ch.motor_action, res_ch.motor_speed,
                       res_ch.pid_clear);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_seen++;
                check_field("mode", 8'(want.mode), 8'(res_ch.mode));
                check_field("motor_action", 8'(want.motor_action),
                            8'(res_ch.motor_action));
                check_field("motor_speed", 8'(want.motor_speed),
                            8'(res_ch.motor_speed));
                check_field("pid_clear", 8'(want.pid_clear), 8'(res_ch.pid_clear));
            end
        end
    end

    // Result back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any transfer or register write restarts the count
    always @(posedge clk)
    begin
        if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d results pending",
                     STALL_LIMIT, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one tick after a random gap and hold it until the transfer
    task automatic send_tick(input tick_t t, input logic known, input result_t res);
        int unsigned gap;
        tick_note_t  note;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        note.known = known;
        note.res   = res;
        tick_notes.push_back(note);
        tick_ch.valid     <= 1'b1;
        tick_ch.cmd_valid <= t.cmd_valid;
        tick_ch.nav_cmd   <= t.nav_cmd;
        tick_ch.obstacle  <= t.obstacle;
        tick_ch.line_seen <= t.line_seen;
        tick_ch.line_pos  <= t.line_pos;
        tick_ch.now_ms    <= t.now_ms;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait out every pending result
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    initial
    begin : run
        tick_t       t;
        int          v;
        logic        obs_on;
        logic        line_on;
        logic [31:0] ms_clock;
        logic [14:0] thr;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_LOST_TIMEOUT;
        cfg_data          = '0;
        tick_ch.valid     = 1'b0;
        tick_ch.cmd_valid = 1'b0;
        tick_ch.nav_cmd   = NAV_STOP;
        tick_ch.obstacle  = 1'b0;
        tick_ch.line_seen = 1'b0;
        tick_ch.line_pos  = '0;
        tick_ch.now_ms    = '0;

        // cmd_valid, nav_cmd, obstacle, line_seen, line_pos, now_ms | known, result
        probe_rows = '{
            // idle with a stray command field
            '{'{1'b0, NAV_RIGHT, 1'b0, 1'b1, 16'sd0, 32'd0},
              1'b1, '{MODE_CODE_IDLE, ACT_NONE, 7'd0, 1'b0}},
            '{'{1'b0, NAV_STOP, 1'b1, 1'b0, 16'sd0, 32'd10},
              1'b1, '{MODE_CODE_STOP, ACT_STOP, 7'd0, 1'b0}},
            // command arrives under an obstacle
            '{'{1'b1, NAV_FWD, 1'b1, 1'b1, 16'sd0, 32'd20}, 1'b0, NO_RES},
            // obstacle while stopped: no new stop order
            '{'{1'b0, NAV_STOP, 1'b1, 1'b1, 16'sd0, 32'd30},
              1'b1, '{MODE_CODE_STOP, ACT_NONE, 7'd0, 1'b0}},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b1, 16'sd0, 32'd40}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b0, 16'sd0, 32'd100}, 1'b0, NO_RES},
            // lost timeout exactly reached, then just passed
            '{'{1'b0, NAV_STOP, 1'b0, 1'b0, 16'sd0, 32'd1100}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b0, 16'sd0, 32'd1101}, 1'b0, NO_RES},
            // most negative position saturates
            '{'{1'b0, NAV_STOP, 1'b0, 1'b1, -16'sd32768, 32'd1300}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b1, -16'sd32768, 32'd1400}, 1'b0, NO_RES},
            // threshold is inclusive
            '{'{1'b0, NAV_STOP, 1'b0, 1'b1, -16'sd2048, 32'd1500}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b1, 16'sd32767, 32'd1600}, 1'b0, NO_RES},
            // left command: search and reacquire turn left
            '{'{1'b1, NAV_LEFT, 1'b0, 1'b0, 16'sd0, 32'd5000}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b0, 16'sd0, 32'd6001}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b0, 16'sd0, 32'd6100}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b1, 16'sd2049, 32'd6200}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b1, 16'sd2049, 32'd6300}, 1'b0, NO_RES},
            // unknown command is stored and turns right
            '{'{1'b1, 3'd7, 1'b0, 1'b0, 16'sd0, 32'd6400}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b0, 16'sd0, 32'd6500}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b1, 1'b0, 16'sd0, 32'd6600},
              1'b1, '{MODE_CODE_STOP, ACT_STOP, 7'd0, 1'b0}},
            // clear path after an unknown command stays stopped
            '{'{1'b0, NAV_STOP, 1'b0, 1'b1, 16'sd0, 32'd6700},
              1'b1, '{MODE_CODE_STOP, ACT_NONE, 7'd0, 1'b0}},
            '{'{1'b1, NAV_ROT, 1'b0, 1'b0, 16'sd0, 32'd6800}, 1'b0, NO_RES},
            '{'{1'b1, NAV_STOP, 1'b0, 1'b1, 16'sd0, 32'd6900},
              1'b1, '{MODE_CODE_STOP, ACT_STOP, 7'd0, 1'b0}},
            // lost timeout across the millisecond wrap
            '{'{1'b1, NAV_FWD, 1'b0, 1'b0, 16'sd0, 32'hFFFF_FF00}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b0, 16'sd0, 32'h0000_02E8}, 1'b0, NO_RES},
            '{'{1'b0, NAV_STOP, 1'b0, 1'b0, 16'sd0, 32'h0000_02E9}, 1'b0, NO_RES}
        };

        // timeout, threshold, base, reacquire, rotate; one row per phase, the RAND_PHASE row drawn at random
        reg_plan = '{
            '{16'd0,     16'd0,     16'd0,   16'd0,   16'd0},
            '{16'd65535, 16'd32767, 16'd127, 16'd127, 16'd101},
            '{16'd20,    16'd300,   16'd100, 16'd1,   16'd100},
            '{16'd0,     16'd0,     16'd0,   16'd0,   16'd0},
            '{16'd5,     16'd2048,  16'd50,  16'd30,  16'd40},
            '{16'd250,   16'd100,   16'd75,  16'd100, 16'd0}
        };

        obs_on   = 1'b0;
        line_on  = 1'b1;
        ms_clock = $urandom();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks at reset settings, no idling
        foreach (probe_rows[i])
            send_tick(probe_rows[i].t, probe_rows[i].known, probe_rows[i].res);

        for (int p = 0; p < CFG_PHASES; p++)
        begin
            drain_results();
            for (int r = REG_LOST_TIMEOUT; r <= REG_ROTATE_SPEED; r++)
                write_reg(3'(r), (p == RAND_PHASE) ? 16'($urandom()) : reg_plan[p][r]);
            for (int r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++)
                write_reg(3'(r), 16'($urandom()));
            cfg_we <= 1'b0;

            for (int n = 0; n < RANDOM_TICKS / CFG_PHASES; n++)
            begin
                // Rotate pacing: none, sender gaps, result stalls, both light
                if (n % PACE_SPAN == 0)
                begin
                    case ((n / PACE_SPAN) % 4)
                        0: begin send_idle_pct = 0;  stall_pct = 0;  end
                        1: begin send_idle_pct = 47; stall_pct = 0;  end
                        2: begin send_idle_pct = 0;  stall_pct = 47; end
                        default: begin send_idle_pct = 11; stall_pct = 11; end
                    endcase
                end

                // Sensors change in runs so that modes get time to develop
                if ($urandom_range(11) == 0)
                    obs_on = !obs_on;
                if ($urandom_range(5) == 0)
                    line_on = !line_on;
                if ($urandom_range(40) == 0)
                    ms_clock = $urandom();
                else
                    ms_clock = ms_clock + $urandom_range(nav_cfg.lost_timeout_ms / 3 + 3);

                thr = nav_cfg.reacquire_threshold;
                case ($urandom_range(5))
                    0: v = 0;
                    1: v = int'(thr) + int'($urandom_range(2)) - 1;
                    2: v = -(int'(thr) + int'($urandom_range(2)) - 1);
                    3, 4: v = int'($urandom_range(16'hFFFF));
                    default: v = $urandom_range(1) ? -32768 : 32767;
                endcase

                t.cmd_valid = ($urandom_range(4) == 0);
                t.nav_cmd   = ($urandom_range(4) == 0) ? 3'($urandom_range(7))
                                                       : 3'($urandom_range(NAV_ROT, NAV_FWD));
                t.obstacle  = obs_on;
                t.line_seen = line_on;
                t.line_pos  = 16'(v);
                t.now_ms    = ms_clock;
                send_tick(t, 1'b0, NO_RES);
            end
        end

        drain_results();

        $display("Checked %0d results from %0d ticks (%0d directed) over %0d register settings,",
                 results_seen, ticks_taken, N_PROBES, CFG_PHASES + 1);
        $display("with sender gaps and result stalls at 0, 11 and 47 percent.");
        if (failures == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
